// ----- rtl/core/etq_pkg.sv -----
// Shared types and constants of the event time priority queue.
`timescale 1ns / 1ps
package etq_pkg;

	localparam int TIME_W = 32;
	localparam int REF_W  = 16;
	localparam int QLEN_W = 5;

	localparam logic CMD_ENQ = 1'b0;
	localparam logic CMD_DEQ = 1'b1;

	localparam logic MODE_FIFO = 1'b0;
	localparam logic MODE_PRIO = 1'b1;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic [TIME_W-1:0] ev_time;
		logic [REF_W-1:0]  ev_ref;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_DEQ_WAIT,
		ST_SCAN,
		ST_TAIL,
		ST_RESP
	} ctrl_state_t;

	typedef struct packed {
		logic accept;
		logic rd_head;
		logic deq_commit;
		logic tail_write;
		logic scan_start;
		logic scan_step;
		logic set_full;
		logic set_empty;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic cmd_deq;
		logic empty;
		logic full;
		logic prio;
		logic scan_more;
		logic out_free;
	} dp_stat_t;

endpackage

// ----- rtl/core/etq_if.sv -----
// Channel interfaces of the event time priority queue: request, response, configuration.
`timescale 1ns / 1ps
interface etq_req_if;
	logic                        valid;
	logic                        ready;
	logic                        cmd;
	logic [etq_pkg::TIME_W-1:0]  event_time;
	logic [etq_pkg::REF_W-1:0]   event_ref;

	modport source (output valid, output cmd, output event_time, output event_ref,
		input ready);
	modport sink (input valid, input cmd, input event_time, input event_ref,
		output ready);
endinterface

interface etq_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        out_valid;
	logic [etq_pkg::TIME_W-1:0]  out_time;
	logic [etq_pkg::REF_W-1:0]   out_ref;
	logic [etq_pkg::QLEN_W-1:0]  queue_length;
	logic [1:0]                  status;

	modport source (output valid, output out_valid, output out_time, output out_ref,
		output queue_length, output status, input ready);
	modport sink (input valid, input out_valid, input out_time, input out_ref,
		input queue_length, input status, output ready);
endinterface

interface etq_cfg_if;
	logic valid;
	logic ready;
	logic queue_mode;

	modport source (output valid, output queue_mode, input ready);
	modport sink (input valid, input queue_mode, output ready);
endinterface

// ----- rtl/core/event_time_priority_queue.sv -----
// Top level of the event time priority queue: controller plus datapath.
// Each request goes from dispatch to the response state: a dequeue of a stored event
// through the dequeue wait; an empty dequeue, FIFO, refused or first ordered enqueue
// directly; an ordered enqueue into a non-empty queue through the scan, one step per
// stored event (one entry memory read per cycle), then the tail write. A result held by
// the sink stalls the controller; the next request is taken in the cycle after the load.
// Reset clears the count, head pointer, mode and control; entry memory is left as is.
`timescale 1ns / 1ps
module event_time_priority_queue #(
	parameter int DEPTH = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	etq_cfg_if.sink   cfg,
	etq_req_if.sink   req,
	etq_rsp_if.source rsp
);
	import etq_pkg::*;

	ctrl_cmd_t ctrl_cmd;
	dp_stat_t  dp_stat;
	logic      req_ready;

	// Mode register is always writable; it is sampled when a request is dispatched.
	assign cfg.ready = 1'b1;
	assign req.ready = req_ready;

	// Sequence each request: dispatch, then dequeue read, ordered scan or tail write,
	// then hand the result to the output register once it is free.
	etq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.stat      (dp_stat),
		.cmd       (ctrl_cmd)
	);

	// Hold entries in a circular memory; dequeue advances the head, an ordered enqueue
	// ripples the displaced entries one slot toward the tail as the scan passes them.
	etq_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (ctrl_cmd),
		.stat             (dp_stat),
		.req_cmd          (req.cmd),
		.req_time         (req.event_time),
		.req_ref          (req.event_ref),
		.cfg_we           (cfg.valid && cfg.ready),
		.cfg_mode         (cfg.queue_mode),
		.rsp_ready        (rsp.ready),
		.rsp_valid        (rsp.valid),
		.rsp_out_valid    (rsp.out_valid),
		.rsp_out_time     (rsp.out_time),
		.rsp_out_ref      (rsp.out_ref),
		.rsp_queue_length (rsp.queue_length),
		.rsp_status       (rsp.status)
	);

endmodule

// ----- rtl/core/etq_ctrl.sv -----
// Controller state machine of the event time priority queue.
`timescale 1ns / 1ps
module etq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  etq_pkg::dp_stat_t   stat,
	output etq_pkg::ctrl_cmd_t  cmd
);
	import etq_pkg::*;

	ctrl_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) state_nxt = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				if (stat.cmd_deq) begin
					state_nxt = stat.empty ? ST_RESP : ST_DEQ_WAIT;
				end else if (stat.full) begin
					state_nxt = ST_RESP;
				end else if (stat.prio && !stat.empty) begin
					state_nxt = ST_SCAN;
				end else begin
					state_nxt = ST_RESP;
				end
			end
			ST_DEQ_WAIT: state_nxt = ST_RESP;
			ST_SCAN: begin
				if (!stat.scan_more) state_nxt = ST_TAIL;
			end
			ST_TAIL: state_nxt = ST_RESP;
			ST_RESP: begin
				if (stat.out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready  = 1'b1;
				cmd.accept = req_valid;
			end
			ST_DISPATCH: begin
				if (stat.cmd_deq) begin
					cmd.set_empty = stat.empty;
					cmd.rd_head   = !stat.empty;
				end else if (stat.full) begin
					cmd.set_full = 1'b1;
				end else if (stat.prio && !stat.empty) begin
					cmd.scan_start = 1'b1;
				end else begin
					cmd.tail_write = 1'b1;
				end
			end
			ST_DEQ_WAIT: cmd.deq_commit = 1'b1;
			ST_SCAN:     cmd.scan_step  = 1'b1;
			ST_TAIL:     cmd.tail_write = 1'b1;
			ST_RESP:     cmd.load_out   = stat.out_free;
			default: begin
				cmd       = '0;
				req_ready = 1'b0;
			end
		endcase
	end

endmodule

// ----- rtl/core/etq_dpath.sv -----
// Datapath of the event time priority queue: circular entry memory, pointers, result register.
`timescale 1ns / 1ps
module etq_dpath #(
	parameter int DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  etq_pkg::ctrl_cmd_t            cmd,
	output etq_pkg::dp_stat_t             stat,
	input  logic                          req_cmd,
	input  logic [etq_pkg::TIME_W-1:0]    req_time,
	input  logic [etq_pkg::REF_W-1:0]     req_ref,
	input  logic                          cfg_we,
	input  logic                          cfg_mode,
	input  logic                          rsp_ready,
	output logic                          rsp_valid,
	output logic                          rsp_out_valid,
	output logic [etq_pkg::TIME_W-1:0]    rsp_out_time,
	output logic [etq_pkg::REF_W-1:0]     rsp_out_ref,
	output logic [etq_pkg::QLEN_W-1:0]    rsp_queue_length,
	output logic [1:0]                    rsp_status
);
	import etq_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = PTR_W + 1;

	// Map a logical position to a physical slot relative to the head.
	function automatic logic [PTR_W-1:0] slot(input logic [PTR_W-1:0] base,
		input logic [PTR_W-1:0] off);
		logic [SUM_W-1:0] sum;
		sum = {1'b0, base} + {1'b0, off};
		if (sum >= SUM_W'(DEPTH)) sum = sum - SUM_W'(DEPTH);
		return sum[PTR_W-1:0];
	endfunction

	entry_t mem [DEPTH];
	entry_t rd_q;
	entry_t carry_q;

	logic [PTR_W-1:0] head_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] idx_q;
	logic             mode_q;
	logic             cmd_q;
	logic             found_q;

	logic             res_valid_q;
	entry_t           res_entry_q;
	status_t          res_status_q;

	logic             out_full_q;
	logic             out_valid_q;
	entry_t           out_entry_q;
	logic [QLEN_W-1:0] out_len_q;
	status_t          out_status_q;

	logic [CNT_W-1:0] idx_nxt;
	logic [PTR_W-1:0] head_nxt;
	logic             hit;
	logic             rd_en, wr_en;
	logic [PTR_W-1:0] rd_addr, wr_addr;
	logic [CNT_W+QLEN_W-1:0] len_ext;

	assign idx_nxt  = idx_q + CNT_W'(1);
	assign head_nxt = (head_q == PTR_W'(DEPTH - 1)) ? '0 : head_q + PTR_W'(1);
	// Insert point: first stored entry strictly later than the carried event.
	assign hit      = found_q || (rd_q.ev_time > carry_q.ev_time);
	assign len_ext  = {{QLEN_W{1'b0}}, count_q};

	assign stat.cmd_deq   = (cmd_q == CMD_DEQ);
	assign stat.empty     = (count_q == '0);
	assign stat.full      = (count_q == CNT_W'(DEPTH));
	assign stat.prio      = (mode_q == MODE_PRIO);
	assign stat.scan_more = (idx_nxt < count_q);
	assign stat.out_free  = !out_full_q || rsp_ready;

	assign rd_en   = cmd.rd_head || cmd.scan_start || (cmd.scan_step && stat.scan_more);
	assign rd_addr = cmd.scan_step ? slot(head_q, idx_nxt[PTR_W-1:0]) : head_q;
	assign wr_en   = cmd.tail_write || (cmd.scan_step && hit);
	assign wr_addr = cmd.tail_write ? slot(head_q, count_q[PTR_W-1:0])
		: slot(head_q, idx_q[PTR_W-1:0]);

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= carry_q;
	end

	always_ff @(posedge clk) begin
		if (rd_en) rd_q <= mem[rd_addr];
	end

	// Carried event: the incoming one, then each displaced entry during the scan.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			carry_q.ev_time <= req_time;
			carry_q.ev_ref  <= req_ref;
		end else if (cmd.scan_step && hit) begin
			carry_q <= rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			idx_q   <= '0;
			mode_q  <= MODE_FIFO;
			cmd_q   <= CMD_ENQ;
			found_q <= 1'b0;
		end else begin
			if (cfg_we) mode_q <= cfg_mode;
			if (cmd.accept) cmd_q <= req_cmd;
			if (cmd.scan_start) begin
				idx_q   <= '0;
				found_q <= 1'b0;
			end else if (cmd.scan_step) begin
				if (hit) found_q <= 1'b1;
				if (stat.scan_more) idx_q <= idx_nxt;
			end
			if (cmd.deq_commit) begin
				head_q  <= head_nxt;
				count_q <= count_q - CNT_W'(1);
			end else if (cmd.tail_write) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.deq_commit) begin
			res_valid_q  <= 1'b1;
			res_entry_q  <= rd_q;
			res_status_q <= STATUS_OK;
		end else if (cmd.tail_write || cmd.set_full || cmd.set_empty) begin
			res_valid_q  <= 1'b0;
			res_entry_q  <= '0;
			res_status_q <= cmd.set_full ? STATUS_FULL
				: (cmd.set_empty ? STATUS_EMPTY : STATUS_OK);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_full_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_full_q <= 1'b1;
		end else if (rsp_ready) begin
			out_full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_valid_q  <= res_valid_q;
			out_entry_q  <= res_entry_q;
			out_len_q    <= len_ext[QLEN_W-1:0];
			out_status_q <= res_status_q;
		end
	end

	assign rsp_valid        = out_full_q;
	assign rsp_out_valid    = out_valid_q;
	assign rsp_out_time     = out_entry_q.ev_time;
	assign rsp_out_ref      = out_entry_q.ev_ref;
	assign rsp_queue_length = out_len_q;
	assign rsp_status       = out_status_q;

endmodule

// ----- test/event_time_priority_queue_tb.sv -----
// Self-checking testbench of the event time priority queue: directed and random traffic.
`timescale 1ns / 1ps
module event_time_priority_queue_tb;
	import etq_pkg::*;

	localparam int DEPTH       = 16;
	localparam int PHASES      = 12;
	localparam int PHASE_ITEMS = 160;
	localparam int IDLE_PCT    = 12;
	localparam int PARK_CYCLES = 400;
	localparam int MAX_REPORTS = 10;

	// One response as the block should present it.
	typedef struct {
		logic                 out_valid;
		logic [TIME_W-1:0]    out_time;
		logic [REF_W-1:0]     out_ref;
		logic [QLEN_W-1:0]    queue_length;
		status_t              status;
	} outcome_t;

	// Mirror of the stored events plus the queue of responses still owed by the block.
	class queue_mirror;
		entry_t   slots[$];
		logic     mode = MODE_FIFO;
		outcome_t owed[$];
		int       errors = 0;

		// Apply one accepted request to the mirror and queue the response it owes.
		function void apply_request(logic cmd, logic [TIME_W-1:0] t, logic [REF_W-1:0] r);
			outcome_t res;
			entry_t   e;
			int       pos;
			int       i;
			res.out_valid = 1'b0;
			res.out_time  = '0;
			res.out_ref   = '0;
			res.status    = STATUS_OK;
			if (cmd == CMD_DEQ) begin
				if (slots.size() == 0) begin
					res.status = STATUS_EMPTY;
				end else begin
					e             = slots.pop_front();
					res.out_valid = 1'b1;
					res.out_time  = e.ev_time;
					res.out_ref   = e.ev_ref;
				end
			end else if (slots.size() >= DEPTH) begin
				res.status = STATUS_FULL;
			end else begin
				pos = slots.size();
				// Ordered mode: go before the first strictly later entry, so ties stay FIFO.
				if (mode == MODE_PRIO) begin
					for (i = 0; i < slots.size(); i++) begin
						if (slots[i].ev_time > t) begin
							pos = i;
							break;
						end
					end
				end
				e.ev_time = t;
				e.ev_ref  = r;
				slots.insert(pos, e);
			end
			res.queue_length = QLEN_W'(slots.size());
			owed.push_back(res);
		endfunction

		// Compare one accepted response with the oldest owed one.
		function void check_response(outcome_t got);
			outcome_t want;
			if (owed.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("[%0t] unexpected response: valid=%0b time=%h ref=%h len=%0d st=%0d",
						$realtime, got.out_valid, got.out_time, got.out_ref,
						got.queue_length, got.status);
				return;
			end
			want = owed.pop_front();
			if (got.out_valid !== want.out_valid || got.out_time !== want.out_time ||
					got.out_ref !== want.out_ref || got.queue_length !== want.queue_length ||
					got.status !== want.status) begin
				errors++;
				if (errors <= MAX_REPORTS) begin
					$display("[%0t] mismatch: expected valid=%0b time=%h ref=%h len=%0d st=%0d",
						$realtime, want.out_valid, want.out_time, want.out_ref,
						want.queue_length, want.status);
					$display("[%0t]           actual   valid=%0b time=%h ref=%h len=%0d st=%0d",
						$realtime, got.out_valid, got.out_time, got.out_ref,
						got.queue_length, got.status);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	etq_cfg_if cfg ();
	etq_req_if req ();
	etq_rsp_if rsp ();

	queue_mirror mirror = new();

	// Traffic shaping controls shared by the driver processes.
	bit no_gaps    = 1'b0;
	bit park_rsp   = 1'b0;
	bit rsp_parked = 1'b0;

	// Directed ordered-mode fill: ties, extremes and an out-of-order mix.
	localparam logic [TIME_W-1:0] FILL_TIMES [DEPTH] = '{
		32'd5, 32'd5, 32'hFFFF_FFFF, 32'd0, 32'd5, 32'hFFFF_FFFF, 32'd3, 32'd0,
		32'h8000_0000, 32'h7FFF_FFFF, 32'd3, 32'hFFFF_FFFE, 32'd1, 32'h8000_0000,
		32'd5, 32'd0
	};

	event_time_priority_queue #(
		.DEPTH (DEPTH)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.req    (req),
		.rsp    (rsp)
	);

	always #5 clk = ~clk;

	// Observe every handshake on the sampled, pre-edge values.
	always @(posedge clk) begin
		outcome_t got;
		if (arst_n) begin
			if (cfg.valid && cfg.ready)
				mirror.mode = cfg.queue_mode;
			if (req.valid && req.ready)
				mirror.apply_request(req.cmd, req.event_time, req.event_ref);
			if (rsp.valid && rsp.ready) begin
				got.out_valid    = rsp.out_valid;
				got.out_time     = rsp.out_time;
				got.out_ref      = rsp.out_ref;
				got.queue_length = rsp.queue_length;
				got.status       = status_t'(rsp.status);
				mirror.check_response(got);
			end
		end
	end

	// Response side: random back-pressure, none while gaps are off, full back-pressure while parked.
	always @(posedge clk) begin
		rsp.ready <= !rsp_parked && (no_gaps || $urandom_range(0, 99) >= IDLE_PCT);
	end

	// Park the response side for a long stretch so the block backs up and stops taking requests.
	initial begin
		wait (park_rsp);
		@(posedge clk);
		rsp_parked <= 1'b1;
		repeat (PARK_CYCLES) @(posedge clk);
		rsp_parked <= 1'b0;
	end

	// Hard stop in case the block hangs.
	initial begin
		#5_000_000;
		$display("event_time_priority_queue regression: fail");
		$finish;
	end

	// Hold until every owed response has come back; advance to the next edge first so the
	// monitor has noted the request accepted at the current edge.
	task automatic wait_drained();
		do @(posedge clk); while (mirror.owed.size() != 0);
	endtask

	// Write the mode register; only called with nothing in flight.
	task automatic write_mode(logic m);
		wait_drained();
		repeat (8) @(posedge clk);
		cfg.valid      <= 1'b1;
		cfg.queue_mode <= m;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
	endtask

	// Offer one request, with an optional random gap first; leave valid high on return.
	task automatic send_request(logic cmd, logic [TIME_W-1:0] t, logic [REF_W-1:0] r);
		while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid      <= 1'b1;
		req.cmd        <= cmd;
		req.event_time <= t;
		req.event_ref  <= r;
		do @(posedge clk); while (!req.ready);
	endtask

	// Event time biased toward ties and the ends of the range.
	function automatic logic [TIME_W-1:0] pick_time();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2, 3, 4: return TIME_W'($urandom_range(0, 15));
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [REF_W-1:0] pick_ref();
		case ($urandom_range(0, 15))
			0:       return '0;
			1:       return '1;
			default: return REF_W'($urandom_range(0, 65535));
		endcase
	endfunction

	initial begin
		int ph;
		int n;
		int enq_pct;
		logic cmd;

		arst_n         <= 1'b0;
		cfg.valid      <= 1'b0;
		cfg.queue_mode <= MODE_FIFO;
		req.valid      <= 1'b0;
		req.cmd        <= CMD_ENQ;
		req.event_time <= '0;
		req.event_ref  <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// FIFO after reset: empty dequeue, extreme events, drain back to empty.
		send_request(CMD_DEQ, $urandom(), pick_ref());
		send_request(CMD_ENQ, '0, '0);
		send_request(CMD_ENQ, '1, '1);
		send_request(CMD_DEQ, $urandom(), pick_ref());
		send_request(CMD_DEQ, $urandom(), pick_ref());
		req.valid <= 1'b0;

		// Ordered mode: fill to capacity with ties, refuse one more, pop a few heads.
		write_mode(MODE_PRIO);
		for (n = 0; n < DEPTH; n++)
			send_request(CMD_ENQ, FILL_TIMES[n], (n == DEPTH - 1) ? '1 : REF_W'(n));
		send_request(CMD_ENQ, '0, 16'hA5A5);
		for (n = 0; n < 3; n++)
			send_request(CMD_DEQ, $urandom(), pick_ref());
		req.valid <= 1'b0;

		// Random phases: alternate mode, vary the fill pressure, reshape the gaps.
		for (ph = 0; ph < PHASES; ph++) begin
			write_mode((ph % 2 == 0) ? MODE_FIFO : MODE_PRIO);
			case (ph % 3)
				0:       enq_pct = 75;
				1:       enq_pct = 30;
				default: enq_pct = 52;
			endcase
			no_gaps = (ph == 3);
			if (ph == 5)
				park_rsp = 1'b1;
			for (n = 0; n < PHASE_ITEMS; n++) begin
				cmd = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
				send_request(cmd, pick_time(), pick_ref());
			end
			req.valid <= 1'b0;
			no_gaps = 1'b0;
			// Pause the sender until the block has answered everything.
			wait_drained();
		end

		wait_drained();
		repeat (40) @(posedge clk);
		if (mirror.errors == 0 && mirror.owed.size() == 0) begin
			$display("event_time_priority_queue regression: pass");
		end else begin
			$display("event_time_priority_queue regression: fail");
		end
		$finish;
	end

endmodule

// ----- event_time_priority_queue.f -----
rtl/core/etq_pkg.sv
rtl/core/etq_if.sv
rtl/core/etq_ctrl.sv
rtl/core/etq_dpath.sv
rtl/core/event_time_priority_queue.sv
test/event_time_priority_queue_tb.sv
